@@ src/mssr_pkg.sv @@
// Package for the magnetometer set/reset sequencer.
// Holds the phase and control code types, the readout beat layout and fixed constants.
// No dependencies.
`default_nettype none

package mssr_pkg;

    localparam int FIELD_BITS    = 18;
    localparam int TEMP_BITS     = 12;
    localparam int FIELD_LIMIT   = 128000;
    localparam int TEMP_OFFSET   = 750;
    localparam int SCALE_MUL     = 125;
    localparam int SCALE_SHIFT   = 8;
    localparam int IN_DATA_BITS  = 64;
    localparam int IN_USER_BITS  = 1;
    localparam int OUT_DATA_BITS = 72;
    localparam int OUT_USER_BITS = 4;
    localparam int OUT_PAD_BITS  = OUT_DATA_BITS - 3 * FIELD_BITS - TEMP_BITS;

    typedef enum logic [2:0] {
        PH_SET_PULSE     = 3'd0,
        PH_SET_MEAS      = 3'd1,
        PH_SET_CAPTURE   = 3'd2,
        PH_RESET_PULSE   = 3'd3,
        PH_RESET_MEAS    = 3'd4,
        PH_RESET_CAPTURE = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        CTRL_SET     = 2'd0,
        CTRL_MEASURE = 2'd1,
        CTRL_RESET   = 2'd2
    } t_ctrl_code;

    // Control group of one result beat, in the bit order of the output tuser.
    typedef struct packed {
        logic       fresh;
        t_ctrl_code ctrl_code;
        logic       issue_write;
    } t_ctrl;

    // Readout bytes in the bit order of the input tdata, byte 0 lowest.
    typedef struct packed {
        logic [7:0] temp_raw;
        logic [7:0] low_bits;
        logic [7:0] z_mid;
        logic [7:0] z_high;
        logic [7:0] y_mid;
        logic [7:0] y_high;
        logic [7:0] x_mid;
        logic [7:0] x_high;
    } t_readout;

endpackage

`default_nettype wire

@@ src/mssr_field.sv @@
// One axis of offset cancellation: set minus reset, scaled by 125/256 and saturated.
// Depends on mssr_pkg.
`default_nettype none

module mssr_field
    import mssr_pkg::*;
#(
    parameter int AXIS_BITS = 18
) (
    input  logic [AXIS_BITS-1:0]         i_set_raw,
    input  logic [AXIS_BITS-1:0]         i_reset_raw,
    output logic signed [FIELD_BITS-1:0] o_field
);

    localparam int DIFF_BITS = AXIS_BITS + 1;
    localparam int PROD_BITS = DIFF_BITS + 7;
    localparam logic signed [PROD_BITS-1:0] LIMIT_HI = PROD_BITS'(FIELD_LIMIT);
    localparam logic signed [PROD_BITS-1:0] LIMIT_LO = -LIMIT_HI;

    logic signed [DIFF_BITS-1:0] diff;
    logic signed [PROD_BITS-1:0] prod;
    logic signed [PROD_BITS-1:0] scaled;
    logic signed [PROD_BITS-1:0] clipped;

    always_comb begin
        diff   = signed'({1'b0, i_set_raw}) - signed'({1'b0, i_reset_raw});
        prod   = PROD_BITS'(diff) * PROD_BITS'(SCALE_MUL);
        scaled = prod >>> SCALE_SHIFT;
        if (scaled > LIMIT_HI) begin
            clipped = LIMIT_HI;
        end else if (scaled < LIMIT_LO) begin
            clipped = LIMIT_LO;
        end else begin
            clipped = scaled;
        end
        o_field = FIELD_BITS'(clipped);
    end

endmodule

`default_nettype wire

@@ src/mssr_core.sv @@
// Phase sequencer and measurement state of the set/reset sequencer.
// Depends on mssr_pkg and mssr_field; advances one tick whenever i_step is high.
`default_nettype none

module mssr_core
    import mssr_pkg::*;
#(
    parameter int AXIS_BITS = 18
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_step,
    input  t_readout                     i_readout,
    input  logic                         i_read_ok,
    output t_ctrl                        o_ctrl,
    output logic signed [FIELD_BITS-1:0] o_field_x,
    output logic signed [FIELD_BITS-1:0] o_field_y,
    output logic signed [FIELD_BITS-1:0] o_field_z,
    output logic signed [TEMP_BITS-1:0]  o_temperature
);

    t_phase r_phase, n_phase;
    logic   capture;
    logic   load_set;
    logic   finish;

    logic [AXIS_BITS-1:0] r_latest_x, r_latest_y, r_latest_z;
    logic [AXIS_BITS-1:0] n_latest_x, n_latest_y, n_latest_z;
    logic [AXIS_BITS-1:0] r_set_x, r_set_y, r_set_z;
    logic [AXIS_BITS-1:0] n_set_x, n_set_y, n_set_z;
    logic signed [FIELD_BITS-1:0] r_field_x, r_field_y, r_field_z;
    logic signed [FIELD_BITS-1:0] n_field_x, n_field_y, n_field_z;
    logic signed [FIELD_BITS-1:0] calc_x, calc_y, calc_z;
    logic signed [TEMP_BITS-1:0]  r_temp, n_temp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SET_PULSE;
        end else if (i_step) begin
            r_phase <= n_phase;
        end
    end

    always_comb begin
        n_phase  = PH_SET_PULSE;
        o_ctrl   = '0;
        capture  = 1'b0;
        load_set = 1'b0;
        finish   = 1'b0;
        unique case (r_phase)
            PH_SET_PULSE: begin
                o_ctrl.issue_write = 1'b1;
                o_ctrl.ctrl_code   = CTRL_SET;
                n_phase            = PH_SET_MEAS;
            end
            PH_SET_MEAS: begin
                o_ctrl.issue_write = 1'b1;
                o_ctrl.ctrl_code   = CTRL_MEASURE;
                n_phase            = PH_SET_CAPTURE;
            end
            PH_SET_CAPTURE: begin
                capture  = 1'b1;
                load_set = 1'b1;
                n_phase  = PH_RESET_PULSE;
            end
            PH_RESET_PULSE: begin
                o_ctrl.issue_write = 1'b1;
                o_ctrl.ctrl_code   = CTRL_RESET;
                n_phase            = PH_RESET_MEAS;
            end
            PH_RESET_MEAS: begin
                o_ctrl.issue_write = 1'b1;
                o_ctrl.ctrl_code   = CTRL_MEASURE;
                n_phase            = PH_RESET_CAPTURE;
            end
            PH_RESET_CAPTURE: begin
                capture      = 1'b1;
                finish       = 1'b1;
                o_ctrl.fresh = 1'b1;
                n_phase      = PH_SET_PULSE;
            end
            default: begin
                n_phase = PH_SET_PULSE;
            end
        endcase
    end

    always_comb begin
        n_latest_x = r_latest_x;
        n_latest_y = r_latest_y;
        n_latest_z = r_latest_z;
        n_temp     = r_temp;
        if (capture && i_read_ok) begin
            n_latest_x = AXIS_BITS'({i_readout.x_high, i_readout.x_mid,
                                     i_readout.low_bits[7:6]});
            n_latest_y = AXIS_BITS'({i_readout.y_high, i_readout.y_mid,
                                     i_readout.low_bits[5:4]});
            n_latest_z = AXIS_BITS'({i_readout.z_high, i_readout.z_mid,
                                     i_readout.low_bits[3:2]});
            n_temp     = signed'({1'b0, i_readout.temp_raw, 3'b000})
                         - TEMP_BITS'(TEMP_OFFSET);
        end
        n_set_x = load_set ? n_latest_x : r_set_x;
        n_set_y = load_set ? n_latest_y : r_set_y;
        n_set_z = load_set ? n_latest_z : r_set_z;
        n_field_x = finish ? calc_x : r_field_x;
        n_field_y = finish ? calc_y : r_field_y;
        n_field_z = finish ? calc_z : r_field_z;
    end

    mssr_field #(.AXIS_BITS(AXIS_BITS)) u_field_x (
        .i_set_raw   (r_set_x),
        .i_reset_raw (n_latest_x),
        .o_field     (calc_x)
    );

    mssr_field #(.AXIS_BITS(AXIS_BITS)) u_field_y (
        .i_set_raw   (r_set_y),
        .i_reset_raw (n_latest_y),
        .o_field     (calc_y)
    );

    mssr_field #(.AXIS_BITS(AXIS_BITS)) u_field_z (
        .i_set_raw   (r_set_z),
        .i_reset_raw (n_latest_z),
        .o_field     (calc_z)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_latest_x <= '0;
            r_latest_y <= '0;
            r_latest_z <= '0;
            r_set_x    <= '0;
            r_set_y    <= '0;
            r_set_z    <= '0;
            r_field_x  <= '0;
            r_field_y  <= '0;
            r_field_z  <= '0;
            r_temp     <= -TEMP_BITS'(TEMP_OFFSET);
        end else if (i_step) begin
            r_latest_x <= n_latest_x;
            r_latest_y <= n_latest_y;
            r_latest_z <= n_latest_z;
            r_set_x    <= n_set_x;
            r_set_y    <= n_set_y;
            r_set_z    <= n_set_z;
            r_field_x  <= n_field_x;
            r_field_y  <= n_field_y;
            r_field_z  <= n_field_z;
            r_temp     <= n_temp;
        end
    end

    assign o_field_x     = n_field_x;
    assign o_field_y     = n_field_y;
    assign o_field_z     = n_field_z;
    assign o_temperature = n_temp;

endmodule

`default_nettype wire

@@ src/magnetometer_set_reset_sequencer.sv @@
// Top level of the magnetometer set/reset sequencer: input register, core, result register.
// Depends on mssr_pkg and mssr_core.
//
// Each input beat is one timer tick and gives exactly one output beat. The block takes
// a beat in every cycle unless the result side stalls; a beat passes through the input
// register and the result register, and the phase sequencer with the three scaling
// lanes stands between them. The cycle of six ticks requests a set pulse, a measurement,
// captures the set readings, requests a reset pulse, a measurement, then captures the
// reset readings and shows set minus reset per axis in 1/16 mG with the fresh flag.
`default_nettype none

module magnetometer_set_reset_sequencer
    import mssr_pkg::*;
#(
    parameter int AXIS_BITS = 18
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_s_axis_tvalid,
    output logic                     o_s_axis_tready,
    // x_high, x_mid, y_high, y_mid, z_high, z_mid, low_bits, temp_raw
    input  logic [IN_DATA_BITS-1:0]  i_s_axis_tdata,
    // read_ok
    input  logic [IN_USER_BITS-1:0]  i_s_axis_tuser,
    output logic                     o_m_axis_tvalid,
    input  logic                     i_m_axis_tready,
    // field_x, field_y, field_z, temperature, zero padding
    output logic [OUT_DATA_BITS-1:0] o_m_axis_tdata,
    // issue_write, ctrl_code (2 bits), fresh
    output logic [OUT_USER_BITS-1:0] o_m_axis_tuser
);

    logic     r_in_valid;
    t_readout r_in_data;
    logic     r_in_read_ok;
    logic     advance;

    logic                     r_out_valid;
    logic [OUT_DATA_BITS-1:0] r_out_tdata;
    t_ctrl                    r_out_ctrl;

    t_ctrl                        core_ctrl;
    logic signed [FIELD_BITS-1:0] core_field_x, core_field_y, core_field_z;
    logic signed [TEMP_BITS-1:0]  core_temp;

    assign advance         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_data    <= t_readout'(i_s_axis_tdata);
            r_in_read_ok <= i_s_axis_tuser[0];
        end
    end

    mssr_core #(.AXIS_BITS(AXIS_BITS)) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (advance),
        .i_readout     (r_in_data),
        .i_read_ok     (r_in_read_ok),
        .o_ctrl        (core_ctrl),
        .o_field_x     (core_field_x),
        .o_field_y     (core_field_y),
        .o_field_z     (core_field_z),
        .o_temperature (core_temp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_tdata <= {{OUT_PAD_BITS{1'b0}}, core_temp, core_field_z,
                            core_field_y, core_field_x};
            r_out_ctrl  <= core_ctrl;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_tdata;
    assign o_m_axis_tuser  = r_out_ctrl;

    // A held input beat is neither dropped nor altered while the result side stalls.
    a_in_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> (r_in_valid && $stable(r_in_data)
                                       && $stable(r_in_read_ok)))
        else $error("input beat lost while stalled");

    // The finishing tick never requests a control write and carries the set code.
    a_fresh_no_write : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_ctrl.fresh) |-> (!r_out_ctrl.issue_write
                                               && r_out_ctrl.ctrl_code == CTRL_SET))
        else $error("fresh result carries a control write");

    // Field results only change on a beat that carries the fresh flag; the check watches field_x.
    a_fields_on_fresh : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && !core_ctrl.fresh && $past(advance) && $past(i_rst_n))
        |-> (core_field_x == r_out_tdata[FIELD_BITS-1:0]))
        else $error("field changed without fresh");

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// Self-checking testbench for the magnetometer set/reset sequencer.
// Drives timer ticks with random readout bytes and compares every result beat with a
// built-in predictor of the six-phase cycle. Depends on mssr_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_top;
    import mssr_pkg::*;

    localparam int AXIS_BITS   = 18;
    localparam int CYCLE_LIMIT = 600000;

    typedef struct {
        logic                         issue_write;
        t_ctrl_code                   ctrl_code;
        logic                         fresh;
        logic signed [FIELD_BITS-1:0] field_x;
        logic signed [FIELD_BITS-1:0] field_y;
        logic signed [FIELD_BITS-1:0] field_z;
        logic signed [TEMP_BITS-1:0]  temperature;
    } t_tick_result;

    logic                     i_clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     s_tvalid = 1'b0;
    logic [IN_DATA_BITS-1:0]  s_tdata = '0;
    logic [IN_USER_BITS-1:0]  s_tuser = '0;
    logic                     m_tready = 1'b0;
    wire                      s_tready;
    wire                      m_tvalid;
    wire [OUT_DATA_BITS-1:0]  m_tdata;
    wire [OUT_USER_BITS-1:0]  m_tuser;

    t_tick_result pending_results[$];
    int           errors = 0;
    int           ticks_sent = 0;
    int           fresh_seen = 0;
    int           cycle_count = 0;
    bit           tx_idle_en = 1'b0;
    bit           rx_idle_en = 1'b0;
    int           rx_hold_left = 0;

    t_phase                       seq_phase;
    logic [AXIS_BITS-1:0]         raw_x, raw_y, raw_z;
    logic [AXIS_BITS-1:0]         set_x, set_y, set_z;
    logic signed [FIELD_BITS-1:0] out_x, out_y, out_z;
    logic signed [TEMP_BITS-1:0]  out_temp;

    magnetometer_set_reset_sequencer #(.AXIS_BITS(AXIS_BITS)) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("magnetometer_set_reset_sequencer test failed");
            $finish;
        end
    end

    function automatic logic signed [FIELD_BITS-1:0] offset_field(
        input logic [AXIS_BITS-1:0] s, input logic [AXIS_BITS-1:0] r);
        int q;
        q = ((int'(s) - int'(r)) * SCALE_MUL) >>> SCALE_SHIFT;
        if (q > FIELD_LIMIT) q = FIELD_LIMIT;
        if (q < -FIELD_LIMIT) q = -FIELD_LIMIT;
        return q[FIELD_BITS-1:0];
    endfunction

    function automatic void capture_readout(input t_readout rd, input logic ok);
        int mask;
        int t;
        mask = (1 << AXIS_BITS) - 1;
        if (!ok) return;
        raw_x = AXIS_BITS'(int'({rd.x_high, rd.x_mid, rd.low_bits[7:6]}) & mask);
        raw_y = AXIS_BITS'(int'({rd.y_high, rd.y_mid, rd.low_bits[5:4]}) & mask);
        raw_z = AXIS_BITS'(int'({rd.z_high, rd.z_mid, rd.low_bits[3:2]}) & mask);
        t = int'(rd.temp_raw) * 8 - TEMP_OFFSET;
        out_temp = t[TEMP_BITS-1:0];
    endfunction

    function automatic t_tick_result predict_tick(input t_readout rd, input logic ok);
        t_tick_result res;
        res.issue_write = 1'b0;
        res.ctrl_code   = CTRL_SET;
        res.fresh       = 1'b0;
        case (seq_phase)
            PH_SET_PULSE: begin
                res.issue_write = 1'b1;
                res.ctrl_code   = CTRL_SET;
                seq_phase       = PH_SET_MEAS;
            end
            PH_SET_MEAS: begin
                res.issue_write = 1'b1;
                res.ctrl_code   = CTRL_MEASURE;
                seq_phase       = PH_SET_CAPTURE;
            end
            PH_SET_CAPTURE: begin
                capture_readout(rd, ok);
                set_x     = raw_x;
                set_y     = raw_y;
                set_z     = raw_z;
                seq_phase = PH_RESET_PULSE;
            end
            PH_RESET_PULSE: begin
                res.issue_write = 1'b1;
                res.ctrl_code   = CTRL_RESET;
                seq_phase       = PH_RESET_MEAS;
            end
            PH_RESET_MEAS: begin
                res.issue_write = 1'b1;
                res.ctrl_code   = CTRL_MEASURE;
                seq_phase       = PH_RESET_CAPTURE;
            end
            PH_RESET_CAPTURE: begin
                capture_readout(rd, ok);
                out_x     = offset_field(set_x, raw_x);
                out_y     = offset_field(set_y, raw_y);
                out_z     = offset_field(set_z, raw_z);
                res.fresh = 1'b1;
                seq_phase = PH_SET_PULSE;
            end
            default: seq_phase = PH_SET_PULSE;
        endcase
        res.field_x     = out_x;
        res.field_y     = out_y;
        res.field_z     = out_z;
        res.temperature = out_temp;
        return res;
    endfunction

    function automatic int pick_gap();
        if ($urandom_range(0, 19) == 0) return $urandom_range(12, 48);
        return $urandom_range(1, 3);
    endfunction

    task automatic send_tick(input t_readout rd, input logic ok);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= rd;
        s_tuser  <= ok;
        do @(posedge i_clk); while (!s_tready);
        pending_results.push_back(predict_tick(rd, ok));
        ticks_sent++;
        gap = (tx_idle_en && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic t_readout readout_of(input logic [AXIS_BITS-1:0] x,
        input logic [AXIS_BITS-1:0] y, input logic [AXIS_BITS-1:0] z, input logic [7:0] t);
        t_readout rd;
        rd.x_high   = x[17:10];
        rd.x_mid    = x[9:2];
        rd.y_high   = y[17:10];
        rd.y_mid    = y[9:2];
        rd.z_high   = z[17:10];
        rd.z_mid    = z[9:2];
        rd.low_bits = {x[1:0], y[1:0], z[1:0], 2'($urandom)};
        rd.temp_raw = t;
        return rd;
    endfunction

    function automatic t_readout random_readout();
        return t_readout'({$urandom, $urandom});
    endfunction

    task automatic run_cycle(input t_readout set_rd, input logic set_ok,
        input t_readout reset_rd, input logic reset_ok);
        send_tick(random_readout(), 1'($urandom));
        send_tick(random_readout(), 1'($urandom));
        send_tick(set_rd, set_ok);
        send_tick(random_readout(), 1'($urandom));
        send_tick(random_readout(), 1'($urandom));
        send_tick(reset_rd, reset_ok);
    endtask

    task automatic test_directed_extremes();
        run_cycle(readout_of('1, '1, '1, 8'hFF), 1'b1, readout_of('0, '0, '0, 8'h00), 1'b1);
        run_cycle(readout_of('0, '0, '0, 8'h00), 1'b1, readout_of('1, '1, '1, 8'hFF), 1'b1);
        run_cycle(random_readout(), 1'b0, random_readout(), 1'b1);
        run_cycle(random_readout(), 1'b1, random_readout(), 1'b0);
    endtask

    task automatic test_random_ticks(input int count);
        t_readout rd;
        int       chunk;
        int       sel;
        while (count > 0) begin
            chunk      = $urandom_range(30, 150);
            if (chunk > count) chunk = count;
            tx_idle_en = ($urandom_range(0, 3) != 0);
            rx_idle_en = ($urandom_range(0, 3) != 0);
            repeat (chunk) begin
                sel = $urandom_range(0, 19);
                if (sel == 0) rd = '0;
                else if (sel == 1) rd = '1;
                else rd = random_readout();
                send_tick(rd, $urandom_range(0, 9) != 0);
                count--;
            end
        end
    endtask

    task automatic test_output_hold();
        tx_idle_en   = 1'b0;
        rx_hold_left = 300;
        repeat (80) send_tick(random_readout(), 1'b1);
    endtask

    task automatic test_drain_pause();
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        repeat (30) send_tick(random_readout(), $urandom_range(0, 4) != 0);
        s_tvalid <= 1'b0;
        wait (pending_results.size() == 0);
        @(posedge i_clk);
        repeat (30) send_tick(random_readout(), $urandom_range(0, 4) != 0);
    endtask

    initial begin : rx_ready
        int idle_left;
        idle_left = 0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_left > 0) begin
                m_tready <= 1'b0;
                rx_hold_left--;
            end else if (idle_left > 0) begin
                m_tready <= 1'b0;
                idle_left--;
            end else begin
                m_tready <= 1'b1;
                if (rx_idle_en && $urandom_range(0, 3) == 0) idle_left = pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin : field_checker
        t_tick_result want;
        t_ctrl        got_ctrl;
        logic signed [FIELD_BITS-1:0] got_x, got_y, got_z;
        logic signed [TEMP_BITS-1:0]  got_temp;
        if (rst_n && m_tvalid && m_tready) begin
            got_ctrl = t_ctrl'(m_tuser);
            got_x    = m_tdata[FIELD_BITS-1:0];
            got_y    = m_tdata[2*FIELD_BITS-1:FIELD_BITS];
            got_z    = m_tdata[3*FIELD_BITS-1:2*FIELD_BITS];
            got_temp = m_tdata[3*FIELD_BITS+TEMP_BITS-1:3*FIELD_BITS];
            if (got_ctrl.fresh === 1'b1) fresh_seen++;
            if (pending_results.size() == 0) begin
                $error("result beat with no tick waiting");
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (got_ctrl.issue_write !== want.issue_write) begin
                    $error("issue_write: expected %0d, got %0d", want.issue_write,
                        got_ctrl.issue_write);
                    errors++;
                end
                if (got_ctrl.ctrl_code !== want.ctrl_code) begin
                    $error("ctrl_code: expected %0d, got %0d", want.ctrl_code,
                        got_ctrl.ctrl_code);
                    errors++;
                end
                if (got_ctrl.fresh !== want.fresh) begin
                    $error("fresh: expected %0d, got %0d", want.fresh, got_ctrl.fresh);
                    errors++;
                end
                if (got_x !== want.field_x) begin
                    $error("field_x: expected %0d, got %0d", want.field_x, got_x);
                    errors++;
                end
                if (got_y !== want.field_y) begin
                    $error("field_y: expected %0d, got %0d", want.field_y, got_y);
                    errors++;
                end
                if (got_z !== want.field_z) begin
                    $error("field_z: expected %0d, got %0d", want.field_z, got_z);
                    errors++;
                end
                if (got_temp !== want.temperature) begin
                    $error("temperature: expected %0d, got %0d", want.temperature, got_temp);
                    errors++;
                end
            end
        end
    end

    initial begin
        seq_phase = PH_SET_PULSE;
        raw_x = '0; raw_y = '0; raw_z = '0;
        set_x = '0; set_y = '0; set_z = '0;
        out_x = '0; out_y = '0; out_z = '0;
        out_temp = TEMP_BITS'(-TEMP_OFFSET);
        repeat (11) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_extremes();
        test_random_ticks(1200);
        test_output_hold();
        test_drain_pause();

        s_tvalid <= 1'b0;
        rx_idle_en = 1'b0;
        wait (pending_results.size() == 0);
        repeat (10) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $error("%0d expected result beats never arrived", pending_results.size());
            errors++;
        end

        $display("Ran %0d ticks through %0d completed set/reset cycles,", ticks_sent, fresh_seen);
        $display("with failed reads, extreme readouts, long output stalls and idle gaps.");
        if (errors == 0) begin
            $display("magnetometer_set_reset_sequencer test passed");
        end else begin
            $display("magnetometer_set_reset_sequencer test failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
src/mssr_pkg.sv
src/mssr_field.sv
src/mssr_core.sv
src/magnetometer_set_reset_sequencer.sv
tb/tb_top.sv
